/* rtl/tddl_pkg.sv */
// Shared types, codes and constants for the tile directory decode and lookup unit.
// Depends on nothing; every other file refers to it by scoped names.
package tddl_pkg;

    // Default capacity of the entry store.
    localparam int MAX_ENTRIES_DEF = 512;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_BYTE   = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Status codes carried in the output tuser.
    localparam logic [2:0] ST_BYTE  = 3'd0;
    localparam logic [2:0] ST_DONE  = 3'd1;
    localparam logic [2:0] ST_ERROR = 3'd2;
    localparam logic [2:0] ST_FOUND = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    // Varint byte fields.
    localparam logic [7:0] VARINT_DATA_MASK = 8'h7F;
    localparam logic [7:0] VARINT_MORE_MASK = 8'h80;
    localparam logic [6:0] VARINT_STEP      = 7'd7;
    localparam logic [6:0] VARINT_LIMIT     = 7'd64;

    // Directory decode phases.
    typedef enum logic [6:0] {
        PH_COUNT = 7'b0000001,
        PH_IDS   = 7'b0000010,
        PH_RUNS  = 7'b0000100,
        PH_LENS  = 7'b0001000,
        PH_OFFS  = 7'b0010000,
        PH_DONE  = 7'b0100000,
        PH_ERROR = 7'b1000000
    } phase_t;

    // One directory entry as held in the store.
    typedef struct packed {
        logic [63:0] id;
        logic [31:0] run;
        logic [31:0] len;
        logic [63:0] off;
    } entry_t;

    // Per-field write request into the entry store.
    typedef struct packed {
        logic   id_we;
        logic   run_we;
        logic   len_we;
        logic   off_we;
        entry_t data;
    } entry_wr_t;

    // Decoder response towards the output register.
    typedef struct packed {
        logic       valid;
        logic [2:0] status;
        logic       dir_ready;
    } dec_rsp_t;

    // Lookup response towards the output register.
    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [63:0] off;
        logic [31:0] len;
        logic [31:0] run;
    } scan_rsp_t;

endpackage

/* rtl/tile_directory_decode_lookup_unit.sv */
// Top level of the tile directory decode and lookup unit.
// Depends on tddl_pkg, tddl_entry_mem, tddl_decoder and tddl_scan.
//
// Every accepted transaction gives exactly one result transaction. A clear, a
// directory byte or an unused command is answered in the cycle after it is
// accepted, and bytes stream at one per cycle while results are taken. A last
// byte that ends the stream early fills the remaining values with zero, one
// value per cycle through the store write port. A lookup walks the stored
// entries through the single registered read port of the entry memory, one
// entry per cycle, and answers at the first matching entry, or once every
// entry has been checked when none matches. A lookup without a completed
// directory, or with an empty one, is answered in the cycle after it is
// accepted. No new transaction is accepted while a fill or a lookup runs.
module tile_directory_decode_lookup_unit #(
    parameter int MAX_ENTRIES = tddl_pkg::MAX_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // data_byte[7:0], query_id[71:8]
    input  logic [1:0]    s_axis_tuser,   // cmd[1:0]
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata,   // entry_count[9:0], tile_offset[73:10],
                                          // tile_length[105:74], run_count[137:106]
    output logic [2:0]    m_axis_tuser    // status[2:0]
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic                 accept;
    logic                 dec_busy;
    logic                 scan_busy;
    logic [IDX_W-1:0]     dec_rd_addr;
    logic [IDX_W-1:0]     scan_rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [CNT_W-1:0]     count_next;
    tddl_pkg::entry_wr_t  wr;
    tddl_pkg::entry_t     rd_data;
    tddl_pkg::dec_rsp_t   dec_rsp;
    tddl_pkg::scan_rsp_t  scan_rsp;

    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           out_status_reg, out_status_next;
    logic [137:0]         out_data_reg, out_data_next;
    logic [9:0]           count_field;

    assign s_axis_tready = !dec_busy && !scan_busy && (!m_axis_tvalid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    tddl_entry_mem #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_addr (scan_busy ? scan_rd_addr : dec_rd_addr),
        .rd_data (rd_data)
    );

    tddl_decoder #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept && (s_axis_tuser == tddl_pkg::CMD_CLEAR)),
        .byte_valid (accept && (s_axis_tuser == tddl_pkg::CMD_BYTE)),
        .data_byte  (s_axis_tdata[7:0]),
        .last_byte  (s_axis_tlast),
        .len_rd     (rd_data.len),
        .rd_addr    (dec_rd_addr),
        .wr_addr    (wr_addr),
        .wr         (wr),
        .busy       (dec_busy),
        .count_next (count_next),
        .rsp        (dec_rsp)
    );

    tddl_scan #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && (s_axis_tuser == tddl_pkg::CMD_QUERY)),
        .query_id  (s_axis_tdata[71:8]),
        .dir_ready (dec_rsp.dir_ready),
        .count     (count_next),
        .rd_data   (rd_data),
        .rd_addr   (scan_rd_addr),
        .busy      (scan_busy),
        .rsp       (scan_rsp)
    );

    assign count_field = dec_rsp.dir_ready ? 10'(count_next) : 10'd0;

    // Result register: loaded by whichever unit finishes a transaction.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;

        if (accept && (s_axis_tuser == tddl_pkg::CMD_CLEAR))
        begin
            out_valid_next  = 1'b1;
            out_status_next = tddl_pkg::ST_CLEAR;
            out_data_next   = '0;
        end
        else if (dec_rsp.valid)
        begin
            out_valid_next  = 1'b1;
            out_status_next = dec_rsp.status;
            out_data_next   = {128'd0, count_field};
        end
        else if (scan_rsp.valid)
        begin
            out_valid_next  = 1'b1;
            out_status_next = scan_rsp.status;
            out_data_next   = {scan_rsp.run, scan_rsp.len, scan_rsp.off, count_field};
        end
        else if (accept && (s_axis_tuser != tddl_pkg::CMD_BYTE)
                 && (s_axis_tuser != tddl_pkg::CMD_QUERY))
        begin
            out_valid_next  = 1'b1;
            out_status_next = tddl_pkg::ST_BYTE;
            out_data_next   = {128'd0, count_field};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

/* rtl/tddl_entry_mem.sv */
// Entry store of the tile directory: one synchronous memory with per-field writes.
// Depends on tddl_pkg for the entry and write request types.
module tddl_entry_mem #(
    parameter int MAX_ENTRIES = tddl_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                       clk,
    input  logic [IDX_W-1:0]           wr_addr,
    input  tddl_pkg::entry_wr_t        wr,
    input  logic [IDX_W-1:0]           rd_addr,
    output tddl_pkg::entry_t           rd_data
);

    tddl_pkg::entry_t mem [MAX_ENTRIES];
    tddl_pkg::entry_t rd_reg;
    logic             hit;

    assign hit     = (wr_addr == rd_addr);
    assign rd_data = rd_reg;

    // Field writes.
    always_ff @(posedge clk)
    begin
        if (wr.id_we)
        begin
            mem[wr_addr].id <= wr.data.id;
        end
        if (wr.run_we)
        begin
            mem[wr_addr].run <= wr.data.run;
        end
        if (wr.len_we)
        begin
            mem[wr_addr].len <= wr.data.len;
        end
        if (wr.off_we)
        begin
            mem[wr_addr].off <= wr.data.off;
        end
    end

    // Registered read; a field written in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        rd_reg.id  <= (wr.id_we  && hit) ? wr.data.id  : mem[rd_addr].id;
        rd_reg.run <= (wr.run_we && hit) ? wr.data.run : mem[rd_addr].run;
        rd_reg.len <= (wr.len_we && hit) ? wr.data.len : mem[rd_addr].len;
        rd_reg.off <= (wr.off_we && hit) ? wr.data.off : mem[rd_addr].off;
    end

endmodule

/* rtl/tddl_decoder.sv */
// Varint stream decoder: builds the directory entries and writes them into the store.
// Depends on tddl_pkg; drives the write port and the decode-side read address.
module tddl_decoder #(
    parameter int MAX_ENTRIES = tddl_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    byte_valid,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    input  logic [31:0]             len_rd,
    output logic [IDX_W-1:0]        rd_addr,
    output logic [IDX_W-1:0]        wr_addr,
    output tddl_pkg::entry_wr_t     wr,
    output logic                    busy,
    output logic [CNT_W-1:0]        count_next,
    output tddl_pkg::dec_rsp_t      rsp
);

    tddl_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] decl_reg, decl_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [63:0]      accum_reg, accum_next;
    logic [6:0]       shift_reg, shift_next;
    logic [63:0]      running_reg, running_next;
    logic             ready_reg, ready_next;
    logic             fill_reg, fill_next;
    logic [63:0]      prev_off_reg, prev_off_next;
    logic [31:0]      prev_len_reg, prev_len_next;

    logic             open_phase;
    logic             processed;
    logic             take_en;
    logic [63:0]      value;
    logic [63:0]      accum_new;
    logic [CNT_W-1:0] idx_inc;
    logic             last_of_section;
    logic             fill_go;
    logic [63:0]      off_value;
    tddl_pkg::phase_t section_next;

    assign busy       = fill_reg;
    assign count_next = decl_next;
    assign rd_addr    = idx_next[IDX_W-1:0];
    assign wr_addr    = idx_reg[IDX_W-1:0];

    // Phases in which stream bytes are still taken.
    always_comb
    begin
        unique case (phase_reg)
            tddl_pkg::PH_COUNT, tddl_pkg::PH_IDS, tddl_pkg::PH_RUNS,
            tddl_pkg::PH_LENS, tddl_pkg::PH_OFFS: open_phase = 1'b1;
            default:                              open_phase = 1'b0;
        endcase
    end

    assign processed = byte_valid && open_phase;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign last_of_section = (idx_inc >= decl_reg);

    // Section that follows the current one.
    always_comb
    begin
        unique case (phase_reg)
            tddl_pkg::PH_IDS:  section_next = tddl_pkg::PH_RUNS;
            tddl_pkg::PH_RUNS: section_next = tddl_pkg::PH_LENS;
            tddl_pkg::PH_LENS: section_next = tddl_pkg::PH_OFFS;
            default:           section_next = tddl_pkg::PH_DONE;
        endcase
    end

    // Byte accumulation, value completion and the entry update it causes.
    always_comb
    begin
        phase_next    = phase_reg;
        decl_next     = decl_reg;
        idx_next      = idx_reg;
        accum_next    = accum_reg;
        shift_next    = shift_reg;
        running_next  = running_reg;
        ready_next    = ready_reg;
        fill_next     = fill_reg;
        prev_off_next = prev_off_reg;
        prev_len_next = prev_len_reg;
        wr            = '0;
        take_en       = 1'b0;
        value         = '0;
        accum_new     = accum_reg;

        if (shift_reg < tddl_pkg::VARINT_LIMIT)
        begin
            accum_new = accum_reg
                      | (64'(data_byte & tddl_pkg::VARINT_DATA_MASK) << shift_reg);
        end

        if (fill_reg)
        begin
            take_en = 1'b1;
        end
        else if (processed)
        begin
            if (((data_byte & tddl_pkg::VARINT_MORE_MASK) == 8'h00) || last_byte)
            begin
                take_en    = 1'b1;
                value      = accum_new;
                accum_next = '0;
                shift_next = '0;
            end
            else
            begin
                accum_next = accum_new;
                if (shift_reg < tddl_pkg::VARINT_LIMIT)
                begin
                    shift_next = shift_reg + tddl_pkg::VARINT_STEP;
                end
            end
        end

        off_value = ((value == 64'd0) && (idx_reg != '0))
                  ? prev_off_reg + 64'(prev_len_reg)
                  : value - 64'd1;

        wr.data.id  = running_reg + value;
        wr.data.run = value[31:0];
        wr.data.len = value[31:0];
        wr.data.off = off_value;

        if (take_en)
        begin
            if (phase_reg == tddl_pkg::PH_COUNT)
            begin
                if (value > 64'(MAX_ENTRIES))
                begin
                    phase_next = tddl_pkg::PH_ERROR;
                end
                else
                begin
                    decl_next = value[CNT_W-1:0];
                    idx_next  = '0;
                    if (value == 64'd0)
                    begin
                        phase_next = tddl_pkg::PH_DONE;
                        ready_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = tddl_pkg::PH_IDS;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    tddl_pkg::PH_IDS:
                    begin
                        wr.id_we     = 1'b1;
                        running_next = wr.data.id;
                    end
                    tddl_pkg::PH_RUNS: wr.run_we = 1'b1;
                    tddl_pkg::PH_LENS: wr.len_we = 1'b1;
                    default:
                    begin
                        wr.off_we     = 1'b1;
                        prev_off_next = off_value;
                        prev_len_next = len_rd;
                    end
                endcase
                if (last_of_section)
                begin
                    idx_next   = '0;
                    phase_next = section_next;
                    if (section_next == tddl_pkg::PH_DONE)
                    begin
                        ready_next = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
        end

        // An early last byte leaves sections to be filled with zero values.
        fill_go = (phase_next == tddl_pkg::PH_IDS) || (phase_next == tddl_pkg::PH_RUNS)
               || (phase_next == tddl_pkg::PH_LENS) || (phase_next == tddl_pkg::PH_OFFS);
        if (processed && last_byte && fill_go)
        begin
            fill_next = 1'b1;
        end
        if (fill_reg && !fill_go)
        begin
            fill_next = 1'b0;
        end

        rsp.valid     = (byte_valid && !(processed && last_byte && fill_go))
                      || (fill_reg && !fill_go);
        rsp.dir_ready = ready_next;
        if ((processed || fill_reg) && (phase_next == tddl_pkg::PH_DONE))
        begin
            rsp.status = tddl_pkg::ST_DONE;
        end
        else if ((processed || fill_reg) && (phase_next == tddl_pkg::PH_ERROR))
        begin
            rsp.status = tddl_pkg::ST_ERROR;
        end
        else
        begin
            rsp.status = tddl_pkg::ST_BYTE;
        end

        // A clear restarts the decoder; the store keeps its contents.
        if (clear)
        begin
            phase_next   = tddl_pkg::PH_COUNT;
            decl_next    = '0;
            idx_next     = '0;
            accum_next   = '0;
            shift_next   = '0;
            running_next = '0;
            ready_next   = 1'b0;
            fill_next    = 1'b0;
            wr           = '0;
        end
    end

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tddl_pkg::PH_COUNT;
            decl_reg     <= '0;
            idx_reg      <= '0;
            accum_reg    <= '0;
            shift_reg    <= '0;
            running_reg  <= '0;
            ready_reg    <= 1'b0;
            fill_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            decl_reg     <= decl_next;
            idx_reg      <= idx_next;
            accum_reg    <= accum_next;
            shift_reg    <= shift_next;
            running_reg  <= running_next;
            ready_reg    <= ready_next;
            fill_reg     <= fill_next;
        end
    end

    // Previous offset and length for offsets coded as a continuation.
    always_ff @(posedge clk)
    begin
        prev_off_reg <= prev_off_next;
        prev_len_reg <= prev_len_next;
    end

endmodule

/* rtl/tddl_scan.sv */
// Lookup engine: walks the entry store in order, one entry per cycle, for a query id.
// Depends on tddl_pkg; reads the store through its registered read port.
module tddl_scan #(
    parameter int MAX_ENTRIES = tddl_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [63:0]             query_id,
    input  logic                    dir_ready,
    input  logic [CNT_W-1:0]        count,
    input  tddl_pkg::entry_t        rd_data,
    output logic [IDX_W-1:0]        rd_addr,
    output logic                    busy,
    output tddl_pkg::scan_rsp_t     rsp
);

    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [63:0]      query_reg;
    logic [63:0]      range_end;
    logic             hit;
    logic             issue_more;

    assign busy       = busy_reg;
    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign issue_more = (issue_reg < count);
    assign range_end  = rd_data.id + 64'(rd_data.run);
    assign hit        = (rd_data.run != 32'd0) && (query_reg >= rd_data.id)
                     && (query_reg < range_end);

    // Issue reads and check each returned entry.
    always_comb
    begin
        busy_next  = busy_reg;
        pend_next  = 1'b0;
        issue_next = issue_reg;
        rsp        = '0;
        rsp.status = tddl_pkg::ST_MISS;

        if (start)
        begin
            if (!dir_ready || (count == '0))
            begin
                rsp.valid = 1'b1;
            end
            else
            begin
                busy_next  = 1'b1;
                issue_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (pend_reg && hit)
            begin
                rsp.valid  = 1'b1;
                rsp.status = tddl_pkg::ST_FOUND;
                rsp.off    = rd_data.off;
                rsp.len    = rd_data.len;
                rsp.run    = rd_data.run;
                busy_next  = 1'b0;
            end
            else if (pend_reg && !issue_more)
            begin
                rsp.valid = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                pend_next = issue_more;
                if (issue_more)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
            end
        end
    end

    // Scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            issue_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
            issue_reg <= issue_next;
        end
    end

    // Query held for the length of the scan.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            query_reg <= query_id;
        end
    end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the tile directory decode and lookup unit.
// Depends on tddl_pkg and tile_directory_decode_lookup_unit; holds its own directory model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_CAP = 512;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [63:0] query_id;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  entry_count;
        logic [63:0] tile_offset;
        logic [31:0] tile_length;
        logic [31:0] run_count;
    } answer_t;

    typedef enum int {DP_COUNT, DP_IDS, DP_RUNS, DP_LENS, DP_OFFS, DP_DONE, DP_ERROR} dphase_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  calm_phase = 0;
    bit  in_taken = 0;
    int  send_gap = 0;
    int  recv_gap = 0;

    // Directory model state.
    dphase_t     dir_phase;
    int          dir_count;
    int          dir_index;
    logic [63:0] vi_accum;
    int          vi_shift;
    logic [63:0] id_sum;
    bit          dir_ready;
    logic [63:0] mdl_ids[DIR_CAP];
    logic [31:0] mdl_runs[DIR_CAP];
    logic [31:0] mdl_lens[DIR_CAP];
    logic [63:0] mdl_offs[DIR_CAP];

    tile_directory_decode_lookup_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void restart_directory();
        dir_phase = DP_COUNT;
        dir_count = 0;
        dir_index = 0;
        vi_accum  = '0;
        vi_shift  = 0;
        id_sum    = '0;
        dir_ready = 0;
    endfunction

    // Step to the next section once the current one holds every entry.
    function automatic void next_entry(dphase_t following);
        dir_index++;
        if (dir_index >= dir_count)
        begin
            dir_index = 0;
            dir_phase = following;
            if (following == DP_DONE)
                dir_ready = 1;
        end
    endfunction

    // Store one finished varint value in the directory.
    function automatic void store_value(logic [63:0] v);
        int i;
        i = dir_index;
        if (dir_phase == DP_COUNT)
        begin
            if (v > DIR_CAP)
                dir_phase = DP_ERROR;
            else
            begin
                dir_count = int'(v);
                dir_index = 0;
                if (v == 0)
                begin
                    dir_phase = DP_DONE;
                    dir_ready = 1;
                end
                else
                    dir_phase = DP_IDS;
            end
            return;
        end
        case (dir_phase)
            DP_IDS:
            begin
                id_sum = id_sum + v;
                mdl_ids[i] = id_sum;
                next_entry(DP_RUNS);
            end
            DP_RUNS:
            begin
                mdl_runs[i] = v[31:0];
                next_entry(DP_LENS);
            end
            DP_LENS:
            begin
                mdl_lens[i] = v[31:0];
                next_entry(DP_OFFS);
            end
            DP_OFFS:
            begin
                if (v == 0 && i > 0)
                    mdl_offs[i] = mdl_offs[i-1] + {32'd0, mdl_lens[i-1]};
                else
                    mdl_offs[i] = v - 64'd1;
                next_entry(DP_DONE);
            end
            default: ;
        endcase
    endfunction

    // Work out the answer to one request and update the directory model.
    function automatic answer_t predict_answer(request_t r);
        answer_t a;
        logic [63:0] hi;
        a = '0;
        if (r.cmd == tddl_pkg::CMD_CLEAR)
        begin
            restart_directory();
            a.status = tddl_pkg::ST_CLEAR;
        end
        else if (r.cmd == tddl_pkg::CMD_BYTE)
        begin
            a.status = tddl_pkg::ST_BYTE;
            if (dir_phase <= DP_OFFS)
            begin
                if (vi_shift < 64)
                    vi_accum = vi_accum
                             | ({56'd0, r.data_byte & tddl_pkg::VARINT_DATA_MASK} << vi_shift);
                if ((r.data_byte & tddl_pkg::VARINT_MORE_MASK) == 0)
                begin
                    hi = vi_accum;
                    vi_accum = '0;
                    vi_shift = 0;
                    store_value(hi);
                end
                else
                begin
                    if (vi_shift < 64)
                        vi_shift += 7;
                    if (r.last_byte)
                    begin
                        hi = vi_accum;
                        vi_accum = '0;
                        vi_shift = 0;
                        store_value(hi);
                    end
                end
                if (r.last_byte)
                    while (dir_phase <= DP_OFFS && dir_phase != DP_COUNT)
                        store_value('0);
                if (dir_phase == DP_DONE)
                    a.status = tddl_pkg::ST_DONE;
                else if (dir_phase == DP_ERROR)
                    a.status = tddl_pkg::ST_ERROR;
            end
        end
        else if (r.cmd == tddl_pkg::CMD_QUERY)
        begin
            a.status = tddl_pkg::ST_MISS;
            if (dir_ready)
                for (int i = 0; i < dir_count; i++)
                begin
                    hi = mdl_ids[i] + {32'd0, mdl_runs[i]};
                    if (mdl_runs[i] != 0 && r.query_id >= mdl_ids[i] && r.query_id < hi)
                    begin
                        a.status = tddl_pkg::ST_FOUND;
                        a.tile_offset = mdl_offs[i];
                        a.tile_length = mdl_lens[i];
                        a.run_count = mdl_runs[i];
                        break;
                    end
                end
        end
        a.entry_count = dir_ready ? dir_count[9:0] : 10'd0;
        return a;
    endfunction

    // Driver: present queued requests, with random gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_requests[0].cmd;
                s_axis_tdata  <= {pending_requests[0].query_id, pending_requests[0].data_byte};
                s_axis_tlast  <= pending_requests[0].last_byte;
                void'(pending_requests.pop_front());
                if (!calm_phase && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 3);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm_phase && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 3);
            end
        end
    end

    // Monitor: predict on accepted requests, check accepted answers.
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_answers.push_back(predict_answer(
                    '{cmd: s_axis_tuser, data_byte: s_axis_tdata[7:0],
                      last_byte: s_axis_tlast, query_id: s_axis_tdata[71:8]}));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{status: m_axis_tuser, entry_count: m_axis_tdata[9:0],
                        tile_offset: m_axis_tdata[73:10], tile_length: m_axis_tdata[105:74],
                        run_count: m_axis_tdata[137:106]};
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.status != want.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    if (got.entry_count != want.entry_count)
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, got.entry_count);
                    if (got.tile_offset != want.tile_offset)
                        $display("%0t: tile_offset expected %h actual %h",
                                 $time, want.tile_offset, got.tile_offset);
                    if (got.tile_length != want.tile_length)
                        $display("%0t: tile_length expected %h actual %h",
                                 $time, want.tile_length, got.tile_length);
                    if (got.run_count != want.run_count)
                        $display("%0t: run_count expected %h actual %h",
                                 $time, want.run_count, got.run_count);
                    if (got != want)
                        fail_count++;
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void push_request(logic [1:0] c, logic [7:0] b, logic l, logic [63:0] q);
        pending_requests.push_back('{cmd: c, data_byte: b, last_byte: l, query_id: q});
    endfunction

    // Queue one varint as bytes; pad adds redundant continuation bytes.
    function automatic void push_varint(logic [63:0] v, int pad, logic end_here);
        logic [7:0] b;
        int n;
        n = 0;
        do
        begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            n++;
            if (v != 0 || pad > 0)
                b[7] = 1'b1;
            push_request(tddl_pkg::CMD_BYTE, b, (end_here && !b[7]), '0);
        end
        while (v != 0);
        for (int k = 0; k < pad; k++)
            push_request(tddl_pkg::CMD_BYTE, (k == pad - 1) ? 8'h00 : 8'h80,
                         (end_here && k == pad - 1), '0);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(0, 3));
            1: return 64'($urandom_range(0, 200));
            2: return 64'($urandom);
            3: return rand64() >> $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    // Build a well-formed directory with random content, optionally cut short.
    // Large directories are always cut early, so the rest comes from the zero fill.
    function automatic void push_directory(int count, bit cut_short);
        int total;
        int cut_at;
        int k;
        total = 1 + 4 * count;
        cut_at = cut_short ? $urandom_range(0, (total > 40) ? 40 : total - 1) : total;
        push_request(tddl_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom), rand64());
        for (k = 0; k < total && k <= cut_at; k++)
        begin
            logic [63:0] v;
            if (k == 0)
                v = 64'(count);
            else if (k <= count)
                v = $urandom_range(0, 3) == 0 ? rand_value() : 64'($urandom_range(0, 40));
            else if (k <= 2 * count)
                v = $urandom_range(0, 4) == 0 ? rand_value() : 64'($urandom_range(0, 20));
            else if (k <= 3 * count)
                v = rand_value();
            else
                v = $urandom_range(0, 1) ? 64'd0 : rand_value();
            if (cut_short && k == cut_at && $urandom_range(0, 1))
            begin
                // Partial varint ends the stream.
                push_request(tddl_pkg::CMD_BYTE, {1'b1, v[6:0]}, 1'b0, '0);
                push_request(tddl_pkg::CMD_BYTE, 8'($urandom) | 8'h80, 1'b1, '0);
            end
            else
                push_varint(v, $urandom_range(0, 9) == 0 ? $urandom_range(1, 10) : 0,
                            k == cut_at);
        end
    endfunction

    // Lookups aimed near stored ids plus a few random ones.
    function automatic void push_queries(int n);
        for (int k = 0; k < n; k++)
        begin
            logic [63:0] q;
            if (dir_phase == DP_DONE && dir_count > 0 && $urandom_range(0, 3) != 0)
            begin
                int e;
                e = $urandom_range(0, dir_count - 1);
                q = mdl_ids[e] + 64'($urandom_range(0, 3)) - 64'd1;
            end
            else
                q = rand64();
            push_request(tddl_pkg::CMD_QUERY, 8'($urandom), 1'($urandom), q);
        end
    endfunction

    task automatic drain();
        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (s_axis_tvalid || expected_answers.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int left;
        int cnt;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tddl_pkg::CMD_CLEAR;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        rst_n = 1'b0;
        restart_directory();
        for (int i = 0; i < DIR_CAP; i++)
        begin
            mdl_ids[i] = '0;
            mdl_runs[i] = '0;
            mdl_lens[i] = '0;
            mdl_offs[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: lookup before a directory, unused command, empty directory,
        // hand-built directory with extremes, oversize count and bytes after it, and an overlong varint.
        push_request(tddl_pkg::CMD_QUERY, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        push_request(tddl_pkg::CMD_UNUSED, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        push_request(tddl_pkg::CMD_BYTE, 8'h00, 1'b0, '0);
        push_request(tddl_pkg::CMD_BYTE, 8'hFF, 1'b1, '0);
        push_request(tddl_pkg::CMD_CLEAR, 8'h00, 1'b0, '0);
        push_varint(64'd2, 0, 0);
        push_varint(64'hFFFF_FFFF_FFFF_FFF0, 0, 0);
        push_varint(64'd100, 0, 0);
        push_varint(64'h1_0000_0005, 0, 0);
        push_varint(64'h7, 0, 0);
        push_varint(64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        push_varint(64'hFFFF_FFFF, 0, 0);
        push_varint(64'd0, 0, 0);
        push_varint(64'd0, 0, 1);
        push_request(tddl_pkg::CMD_QUERY, 8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFF2);
        push_request(tddl_pkg::CMD_QUERY, 8'h00, 1'b0, 64'h0000_0000_0000_0010);
        push_request(tddl_pkg::CMD_QUERY, 8'h00, 1'b0, 64'h0);
        push_request(tddl_pkg::CMD_CLEAR, 8'h00, 1'b0, '0);
        push_varint(64'd513, 0, 0);
        push_request(tddl_pkg::CMD_BYTE, 8'h01, 1'b1, '0);
        push_request(tddl_pkg::CMD_CLEAR, 8'h00, 1'b0, '0);
        for (int k = 0; k < 11; k++)
            push_request(tddl_pkg::CMD_BYTE, 8'hFF, 1'b0, '0);
        push_request(tddl_pkg::CMD_BYTE, 8'h7F, 1'b1, '0);
        drain();

        // Random: directories, mostly small, a few empty, oversize or at full capacity.
        left = 950;
        while (left > 0)
        begin
            int queued_before;
            if (left < 120)
                calm_phase = 1;
            queued_before = pending_requests.size();
            case ($urandom_range(0, 19))
                0: cnt = DIR_CAP;
                1: cnt = $urandom_range(DIR_CAP + 1, 2000);
                2: cnt = 0;
                default: cnt = $urandom_range(1, 8);
            endcase
            if (cnt > DIR_CAP)
            begin
                push_request(tddl_pkg::CMD_CLEAR, 8'h00, 1'b0, '0);
                push_varint(64'(cnt), 0, 0);
                push_request(tddl_pkg::CMD_BYTE, 8'($urandom), 1'($urandom), '0);
            end
            else
                push_directory(cnt, cnt == DIR_CAP || $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0)
                push_request(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom), rand64());
            // Predict phase for query targeting by waiting for the directory.
            left -= pending_requests.size() - queued_before;
            drain();
            push_queries(cnt == DIR_CAP ? 3 : $urandom_range(2, 8));
            left -= 8;
            drain();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0 && expected_answers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
